FILE: rtl/pgs_pkg.sv
// Shared types and constants of the polar Gaussian sample pair block.
// Depends on nothing; imported by pgs_div, pgs_log and the top level (pgs_isqrt does not use it).
package pgs_pkg;

	localparam int unsigned IN_BITS          = 16;
	localparam int unsigned OUT_FRAC_DEFAULT = 12;
	localparam int unsigned OUT_W            = 16;

	localparam int unsigned NORM_W  = 64;
	localparam int unsigned LZ_W    = 6;
	localparam int unsigned M_W     = 31;
	localparam int unsigned EX_W    = 6;
	localparam int unsigned LOG_FRAC = 24;
	localparam int unsigned LVAL_W  = EX_W + LOG_FRAC;
	localparam logic [32:0] TWO_LN2_Q32 = 33'd5954088944;
	localparam int unsigned C_HI_W  = 17;
	localparam int unsigned C_LO_W  = 16;
	localparam int unsigned Q_W     = 39;
	localparam int unsigned LOG_LAT = LOG_FRAC + 3;

	localparam int unsigned RQ_XW   = 56;
	localparam int unsigned R_W     = RQ_XW / 2;
	localparam int unsigned R_FRAC  = 24;
	localparam int unsigned SP_W    = NORM_W - 2;
	localparam int unsigned D_W     = SP_W / 2;
	localparam int unsigned C_W     = 31;
	localparam int unsigned C_FRAC  = 30;

	typedef struct packed {
		logic signed [IN_BITS-1:0] uniform_a;
		logic signed [IN_BITS-1:0] uniform_b;
	} pgs_in_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] normal_sample;
		logic                    is_last;
	} pgs_out_t;

endpackage

FILE: rtl/pgs_isqrt.sv
// Pipelined integer square root, one result bit per stage, with a side tag.
// Self-contained; no package needed.
module pgs_isqrt #(
	parameter int unsigned XW = 56,
	parameter int unsigned TW = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [XW-1:0]     x,
	input  logic [TW-1:0]     tag,
	output logic              out_valid,
	output logic [XW/2-1:0]   root,
	output logic [TW-1:0]     out_tag
);

	localparam int unsigned N = XW / 2;

	logic [XW-1:0] x_s   [N];
	logic [XW-1:0] r_s   [N];
	logic [TW-1:0] tag_s [N];
	logic          v_s   [N];

	for (genvar k = 0; k < N; k++) begin : g_stage
		localparam logic [XW-1:0] BIT = XW'(1) << (XW - 2 - 2 * k);
		logic [XW-1:0] x_in;
		logic [XW-1:0] r_in;
		logic [TW-1:0] tag_in;
		logic          v_in;
		logic [XW-1:0] trial;

		if (k == 0) begin : g_first
			assign x_in   = x;
			assign r_in   = '0;
			assign tag_in = tag;
			assign v_in   = in_valid;
		end else begin : g_next
			assign x_in   = x_s[k-1];
			assign r_in   = r_s[k-1];
			assign tag_in = tag_s[k-1];
			assign v_in   = v_s[k-1];
		end

		assign trial = r_in + BIT;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else begin
				v_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (x_in >= trial) begin
				x_s[k] <= x_in - trial;
				r_s[k] <= (r_in >> 1) + BIT;
			end else begin
				x_s[k] <= x_in;
				r_s[k] <= r_in >> 1;
			end
			tag_s[k] <= tag_in;
		end
	end

	assign out_valid = v_s[N-1];
	assign root      = r_s[N-1][N-1:0];
	assign out_tag   = tag_s[N-1];

endmodule

FILE: rtl/pgs_div.sv
// Pipelined restoring divider giving the Q.30 ratio of a sample to sqrt(s).
// Depends on pgs_pkg for the operand and quotient widths.
module pgs_div
	import pgs_pkg::*;
#(
	parameter int unsigned TW = 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic [D_W-1:0]   num,
	input  logic [D_W-1:0]   den,
	input  logic [TW-1:0]    tag,
	output logic             out_valid,
	output logic [C_W-1:0]   quo,
	output logic [TW-1:0]    out_tag
);

	logic [D_W-1:0] rem_s [C_W];
	logic [D_W-1:0] den_s [C_W];
	logic [C_W-1:0] quo_s [C_W];
	logic [TW-1:0]  tag_s [C_W];
	logic           v_s   [C_W];

	for (genvar k = 0; k < C_W; k++) begin : g_stage
		logic [D_W:0]   trial;
		logic [D_W:0]   diff;
		logic [D_W-1:0] den_in;
		logic [C_W-1:0] quo_in;
		logic [TW-1:0]  tag_in;
		logic           v_in;
		logic           ge;

		if (k == 0) begin : g_first
			assign trial  = {1'b0, num};
			assign den_in = den;
			assign quo_in = '0;
			assign tag_in = tag;
			assign v_in   = in_valid;
		end else begin : g_next
			assign trial  = {rem_s[k-1], 1'b0};
			assign den_in = den_s[k-1];
			assign quo_in = quo_s[k-1];
			assign tag_in = tag_s[k-1];
			assign v_in   = v_s[k-1];
		end

		assign diff = trial - {1'b0, den_in};
		assign ge   = trial >= {1'b0, den_in};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else begin
				v_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			rem_s[k] <= ge ? diff[D_W-1:0] : trial[D_W-1:0];
			den_s[k] <= den_in;
			quo_s[k] <= {quo_in[C_W-2:0], ge};
			tag_s[k] <= tag_in;
		end
	end

	assign out_valid = v_s[C_W-1];
	assign quo       = quo_s[C_W-1];
	assign out_tag   = tag_s[C_W-1];

endmodule

FILE: rtl/pgs_log.sv
// Pipelined -2 ln s: square-and-compare log2 steps, then scaling by 2 ln 2.
// Depends on pgs_pkg for widths and the scaling constant.
module pgs_log
	import pgs_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [M_W-1:0]    m,
	input  logic [EX_W-1:0]   ex,
	output logic              out_valid,
	output logic [Q_W-1:0]    q
);

	localparam int unsigned SQ_W = 2 * M_W;
	localparam int unsigned PH_W = LVAL_W + C_HI_W;
	localparam int unsigned PL_W = LVAL_W + C_LO_W;
	localparam int unsigned PS_W = PH_W + C_LO_W;

	logic [M_W-1:0]      m_s    [LOG_FRAC];
	logic [LOG_FRAC-1:0] frac_s [LOG_FRAC];
	logic [EX_W-1:0]     ex_s   [LOG_FRAC];
	logic                v_s    [LOG_FRAC];

	for (genvar i = 0; i < LOG_FRAC; i++) begin : g_step
		logic [M_W-1:0]      m_in;
		logic [LOG_FRAC-1:0] frac_in;
		logic [EX_W-1:0]     ex_in;
		logic                v_in;
		logic [SQ_W-1:0]     sq;
		logic [M_W:0]        t;

		if (i == 0) begin : g_first
			assign m_in    = m;
			assign frac_in = '0;
			assign ex_in   = ex;
			assign v_in    = in_valid;
		end else begin : g_next
			assign m_in    = m_s[i-1];
			assign frac_in = frac_s[i-1];
			assign ex_in   = ex_s[i-1];
			assign v_in    = v_s[i-1];
		end

		assign sq = SQ_W'(m_in) * SQ_W'(m_in);
		assign t  = sq[SQ_W-1:M_W-1];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i] <= 1'b0;
			end else begin
				v_s[i] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			m_s[i]    <= t[M_W] ? t[M_W:1] : t[M_W-1:0];
			frac_s[i] <= {frac_in[LOG_FRAC-2:0], t[M_W]};
			ex_s[i]   <= ex_in;
		end
	end

	logic [LVAL_W-1:0] lval_s25;
	logic [PH_W-1:0]   phi_s26;
	logic [PL_W-1:0]   plo_s26;
	logic [Q_W-1:0]    q_s27;
	logic              v_s25, v_s26, v_s27;
	logic [PS_W-1:0]   psum;

	assign psum = {phi_s26, {C_LO_W{1'b0}}} + PS_W'(plo_s26);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s25 <= 1'b0;
			v_s26 <= 1'b0;
			v_s27 <= 1'b0;
		end else begin
			v_s25 <= v_s[LOG_FRAC-1];
			v_s26 <= v_s25;
			v_s27 <= v_s26;
		end
	end

	always_ff @(posedge clk) begin
		lval_s25 <= {ex_s[LOG_FRAC-1], {LOG_FRAC{1'b0}}} - LVAL_W'(frac_s[LOG_FRAC-1]);
		phi_s26  <= PH_W'(lval_s25) * PH_W'(TWO_LN2_Q32[32:C_LO_W]);
		plo_s26  <= PL_W'(lval_s25) * PL_W'(TWO_LN2_Q32[C_LO_W-1:0]);
		q_s27    <= psum[LOG_FRAC +: Q_W];
	end

	assign out_valid = v_s27;
	assign q         = q_s27;

endmodule

FILE: rtl/polar_gaussian_sample_pair.sv
// Top level of the polar Gaussian sample pair block.
// Depends on pgs_pkg, pgs_log, pgs_isqrt and pgs_div.
//
// Usage:
// A transaction is a pair of signed uniform samples on operands, taken at a
// rising edge with start high and busy low. busy is high in the cycle after each
// accepted transaction, so no new pair is taken while busy is high.
// The pair feeds one long pipeline: squares and sum, a six-stage normaliser,
// then in parallel a log2 and square-root branch for sqrt(-2 ln s) and a
// square-root and divider branch for u / sqrt(s) and v / sqrt(s), then multiply and round.
// A pair whose s is zero or at least one is dropped silently.
// An accepted pair that is not dropped gives two results on result, each
// shown for one cycle with result_valid high: the first once it has passed
// all pipeline stages, the second in the cycle straight after it, marked is_last.
// Since no pair is taken while busy is high, the single result channel
// that carries two results per pair is never oversubscribed.
// The receiver cannot stall; result_valid is a strobe.
// Reset clears all valid bits and busy; data registers keep no reset.
module polar_gaussian_sample_pair
	import pgs_pkg::*;
#(
	parameter int unsigned OUT_FRAC_BITS = OUT_FRAC_DEFAULT
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	input  pgs_in_t  operands,
	output logic     result_valid,
	output pgs_out_t result
);

	localparam int unsigned SQ_W       = 2 * IN_BITS;
	localparam int unsigned NRM_STAGES = $clog2(NORM_W);
	localparam int unsigned NL         = NRM_STAGES - 1;
	localparam int unsigned LZ_BIAS    = NORM_W - 1 - 2 * (IN_BITS - 1);
	localparam int unsigned TAG_W      = 2 * D_W + 2;
	localparam int unsigned LAT_A      = LOG_LAT + RQ_XW / 2;
	localparam int unsigned LAT_B      = 1 + SP_W / 2 + C_W;
	localparam int unsigned DLY        = LAT_B - LAT_A;
	localparam int unsigned P_W        = R_W + C_W;
	localparam int unsigned PW1        = P_W + 1;
	localparam int unsigned DROP       = R_FRAC + C_FRAC - OUT_FRAC_BITS;
	localparam logic [PW1-1:0] HALF    = PW1'(1) << (DROP - 1);
	localparam logic [PW1-1:0] LIM_POS = PW1'((1 << (OUT_W - 1)) - 1);
	localparam logic [PW1-1:0] LIM_NEG = PW1'(1 << (OUT_W - 1));
	localparam logic [C_W-1:0] C_MAX   = C_W'(1) << C_FRAC;

	function automatic logic [IN_BITS-1:0] magnitude(input logic [IN_BITS-1:0] raw);
		return raw[IN_BITS-1] ? (~raw + 1'b1) : raw;
	endfunction

	function automatic logic [OUT_W-1:0] to_sample(input logic [P_W-1:0] prod, input logic neg);
		logic [PW1-1:0]   mag;
		logic [OUT_W-1:0] res;
		mag = (PW1'(prod) + HALF) >> DROP;
		if (neg) begin
			res = (mag > LIM_NEG) ? LIM_NEG[OUT_W-1:0] : (~mag[OUT_W-1:0] + 1'b1);
		end else begin
			res = (mag > LIM_POS) ? LIM_POS[OUT_W-1:0] : mag[OUT_W-1:0];
		end
		return res;
	endfunction

	// input, squares, sum
	logic               accept;
	logic               v_s1, v_s2, v_s3;
	logic [IN_BITS-1:0] ma_s1, mb_s1, ma_s2, mb_s2, ma_s3, mb_s3;
	logic               na_s1, nb_s1, na_s2, nb_s2, na_s3, nb_s3;
	logic [SQ_W-1:0]    sqa_s2, sqb_s2, sum;
	logic [NORM_W-1:0]  s_s3;
	logic               reject;

	assign accept = start & ~v_s1;
	assign busy   = v_s1;
	assign sum    = sqa_s2 + sqb_s2;
	assign reject = (sum == '0) || (sum[SQ_W-1 -: 2] != 2'b00);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2 & ~reject;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ma_s1 <= magnitude(operands.uniform_a);
			mb_s1 <= magnitude(operands.uniform_b);
			na_s1 <= operands.uniform_a[IN_BITS-1];
			nb_s1 <= operands.uniform_b[IN_BITS-1];
		end
		sqa_s2 <= SQ_W'(ma_s1) * SQ_W'(ma_s1);
		sqb_s2 <= SQ_W'(mb_s1) * SQ_W'(mb_s1);
		ma_s2  <= ma_s1;
		mb_s2  <= mb_s1;
		na_s2  <= na_s1;
		nb_s2  <= nb_s1;
		s_s3   <= NORM_W'(sum);
		ma_s3  <= ma_s2;
		mb_s3  <= mb_s2;
		na_s3  <= na_s2;
		nb_s3  <= nb_s2;
	end

	// normaliser
	logic [NORM_W-1:0]  nrm_s [NRM_STAGES];
	logic [LZ_W-1:0]    lz_s  [NRM_STAGES];
	logic [IN_BITS-1:0] man_s [NRM_STAGES];
	logic [IN_BITS-1:0] mbn_s [NRM_STAGES];
	logic               nan_s [NRM_STAGES];
	logic               nbn_s [NRM_STAGES];
	logic               vn_s  [NRM_STAGES];

	for (genvar j = 0; j < NRM_STAGES; j++) begin : g_nrm
		localparam int unsigned SH = (NORM_W / 2) >> j;
		logic [NORM_W-1:0]  nrm_in;
		logic [LZ_W-1:0]    lz_in;
		logic [IN_BITS-1:0] ma_in, mb_in;
		logic               na_in, nb_in, v_in;
		logic               hit;

		if (j == 0) begin : g_first
			assign nrm_in = s_s3;
			assign lz_in  = '0;
			assign ma_in  = ma_s3;
			assign mb_in  = mb_s3;
			assign na_in  = na_s3;
			assign nb_in  = nb_s3;
			assign v_in   = v_s3;
		end else begin : g_next
			assign nrm_in = nrm_s[j-1];
			assign lz_in  = lz_s[j-1];
			assign ma_in  = man_s[j-1];
			assign mb_in  = mbn_s[j-1];
			assign na_in  = nan_s[j-1];
			assign nb_in  = nbn_s[j-1];
			assign v_in   = vn_s[j-1];
		end

		assign hit = (nrm_in[NORM_W-1 -: SH] == '0);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vn_s[j] <= 1'b0;
			end else begin
				vn_s[j] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			nrm_s[j] <= hit ? (nrm_in << SH) : nrm_in;
			lz_s[j]  <= hit ? (lz_in | LZ_W'(SH)) : lz_in;
			man_s[j] <= ma_in;
			mbn_s[j] <= mb_in;
			nan_s[j] <= na_in;
			nbn_s[j] <= nb_in;
		end
	end

	logic [EX_W-1:0]  ex_n;
	logic [M_W-1:0]   m_n;
	logic [SP_W-1:0]  sp_n;
	logic [LZ_W-2:0]  vsh_n;
	logic [D_W:0]     vpa_full, vpb_full;

	assign ex_n     = lz_s[NL] - LZ_W'(LZ_BIAS);
	assign m_n      = nrm_s[NL][NORM_W-1 -: M_W];
	assign sp_n     = lz_s[NL][0] ? {1'b0, nrm_s[NL][NORM_W-1:3]} : nrm_s[NL][NORM_W-1:2];
	assign vsh_n    = lz_s[NL][LZ_W-1:1] - 1'b1;
	assign vpa_full = (D_W + 1)'(man_s[NL]) << vsh_n;
	assign vpb_full = (D_W + 1)'(mbn_s[NL]) << vsh_n;

	// branch for sqrt(-2 ln s)
	logic             vq;
	logic [Q_W-1:0]   q;
	logic             vr;
	logic [R_W-1:0]   r;

	pgs_log u_log (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vn_s[NL]),
		.m         (m_n),
		.ex        (ex_n),
		.out_valid (vq),
		.q         (q)
	);

	pgs_isqrt #(
		.XW (RQ_XW),
		.TW (1)
	) u_rsqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vq),
		.x         (RQ_XW'({q, 16'h0000})),
		.tag       (1'b0),
		.out_valid (vr),
		.root      (r),
		.out_tag   ()
	);

	logic [R_W-1:0] rd_s  [DLY];
	logic           rvd_s [DLY];

	for (genvar d = 0; d < DLY; d++) begin : g_dly
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				rvd_s[d] <= 1'b0;
			end else begin
				rvd_s[d] <= (d == 0) ? vr : rvd_s[(d == 0) ? 0 : d - 1];
			end
		end
		always_ff @(posedge clk) begin
			rd_s[d] <= (d == 0) ? r : rd_s[(d == 0) ? 0 : d - 1];
		end
	end

	// branch for u / sqrt(s) and v / sqrt(s)
	logic             v_s10;
	logic [SP_W-1:0]  sp_s10;
	logic [D_W-1:0]   vpa_s10, vpb_s10;
	logic             na_s10, nb_s10;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s10 <= 1'b0;
		end else begin
			v_s10 <= vn_s[NL];
		end
	end

	always_ff @(posedge clk) begin
		sp_s10  <= sp_n;
		vpa_s10 <= vpa_full[D_W-1:0];
		vpb_s10 <= vpb_full[D_W-1:0];
		na_s10  <= nan_s[NL];
		nb_s10  <= nbn_s[NL];
	end

	logic             vd;
	logic [D_W-1:0]   den;
	logic [TAG_W-1:0] dtag;

	pgs_isqrt #(
		.XW (SP_W),
		.TW (TAG_W)
	) u_ssqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s10),
		.x         (sp_s10),
		.tag       ({na_s10, nb_s10, vpa_s10, vpb_s10}),
		.out_valid (vd),
		.root      (den),
		.out_tag   (dtag)
	);

	logic             vc_a;
	logic [C_W-1:0]   ca, cb;
	logic             nca, ncb;

	pgs_div #(
		.TW (1)
	) u_div_a (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vd),
		.num       (dtag[2*D_W-1:D_W]),
		.den       (den),
		.tag       (dtag[2*D_W+1]),
		.out_valid (vc_a),
		.quo       (ca),
		.out_tag   (nca)
	);

	pgs_div #(
		.TW (1)
	) u_div_b (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vd),
		.num       (dtag[D_W-1:0]),
		.den       (den),
		.tag       (dtag[2*D_W]),
		.out_valid (),
		.quo       (cb),
		.out_tag   (ncb)
	);

	// product, rounding, saturation
	logic             v_s73, v_s74;
	logic [P_W-1:0]   pa_s73, pb_s73;
	logic             na_s73, nb_s73;
	logic [OUT_W-1:0] za_s74, zb_s74, zb_q;
	logic             pend_q;
	logic [C_W-1:0]   ca_lim, cb_lim;

	assign ca_lim = (ca > C_MAX) ? C_MAX : ca;
	assign cb_lim = (cb > C_MAX) ? C_MAX : cb;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s73        <= 1'b0;
			v_s74        <= 1'b0;
			pend_q       <= 1'b0;
			result_valid <= 1'b0;
		end else begin
			v_s73        <= vc_a;
			v_s74        <= v_s73;
			pend_q       <= v_s74;
			result_valid <= v_s74 | pend_q;
		end
	end

	always_ff @(posedge clk) begin
		pa_s73 <= P_W'(rd_s[DLY-1]) * P_W'(ca_lim);
		pb_s73 <= P_W'(rd_s[DLY-1]) * P_W'(cb_lim);
		na_s73 <= nca;
		nb_s73 <= ncb;
		za_s74 <= to_sample(pa_s73, na_s73);
		zb_s74 <= to_sample(pb_s73, nb_s73);
		if (v_s74) begin
			result.normal_sample <= za_s74;
			result.is_last       <= 1'b0;
			zb_q                 <= zb_s74;
		end else if (pend_q) begin
			result.normal_sample <= zb_q;
			result.is_last       <= 1'b1;
		end
	end

	a_pair: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.is_last |=> result_valid && result.is_last)
		else $error("second sample of a pair not emitted");

	a_spacing: assert property (@(posedge clk) disable iff (!arst_n)
		v_s74 |-> !pend_q)
		else $error("new pair collides with pending second sample");

	a_norm: assert property (@(posedge clk) disable iff (!arst_n)
		vn_s[NL] |-> nrm_s[NL][NORM_W-1])
		else $error("normaliser output not normalised");

	a_align: assert property (@(posedge clk) disable iff (!arst_n)
		vc_a == rvd_s[DLY-1])
		else $error("log and ratio branches out of step");

	a_ratio: assert property (@(posedge clk) disable iff (!arst_n)
		vc_a |-> ca <= C_MAX)
		else $error("ratio above one");

endmodule
